FILE: hdl/lcdfr_pkg.sv
// Package for the LCD fill-rectangle command generator.
// Holds request/result payload types, controller opcodes and item codes.
// No dependencies.
package lcdfr_pkg;

  // Controller RAM span along either axis
  localparam int unsigned RamSpan = 320;

  // Controller opcodes
  localparam logic [7:0] OP_COLSET = 8'h2A;
  localparam logic [7:0] OP_ROWSET = 8'h2B;
  localparam logic [7:0] OP_MEMWR  = 8'h2C;

  // Result item kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_PARAM = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;

  // Orientation values that shift the RAM window
  localparam logic [1:0] ORIENT_COL_SHIFT = 2'd1;
  localparam logic [1:0] ORIENT_ROW_SHIFT = 2'd2;

  // Fill request
  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic        [15:0] fill_color;
  } rect_req_t;

  // Command stream item
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  wire_byte;
    logic [15:0] run_color;
    logic [15:0] run_pixels;
    logic        final_item;
  } fill_item_t;

endpackage

FILE: hdl/lcd_fill_rect_command_gen_core.sv
// Top level of the LCD fill-rectangle command generator.
// Clips a request, applies the RAM offset and emits the window command stream.
// Depends on lcdfr_pkg.
//
// A request passes the input register, the job register and the output
// register before its first item appears. One result item per cycle while the
// output is not stalled, twelve per drawn rectangle; the single item sequencer
// sets the pace. A rectangle clipped to nothing yields no items.
// Reset clears all valid flags and the orientation register to 0.
module lcd_fill_rect_command_gen_core #(
  parameter int unsigned PANEL_COLS = 240,
  parameter int unsigned PANEL_ROWS = 240
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_data_i,
  // requests
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lcdfr_pkg::rect_req_t  in_req_i,
  // items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lcdfr_pkg::fill_item_t out_item_o
);
  import lcdfr_pkg::*;

  localparam int unsigned ColW = $clog2(PANEL_COLS + 1);
  localparam int unsigned RowW = $clog2(PANEL_ROWS + 1);
  localparam int unsigned PixW = ColW + RowW;
  localparam logic signed [16:0] ColsS = 17'(PANEL_COLS);
  localparam logic signed [16:0] RowsS = 17'(PANEL_ROWS);
  localparam logic [15:0] OffX = 16'(RamSpan - PANEL_COLS);
  localparam logic [15:0] OffY = 16'(RamSpan - PANEL_ROWS);
  localparam logic [3:0]  SeqLast = 4'd11;

  // Orientation register
  logic [1:0] orient_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= 2'd0;
    end else if (cfg_valid_i) begin
      orient_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  rect_req_t req_q;
  logic      req_valid_q;
  logic      req_take;

  assign in_ready_o = !req_valid_q || req_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

  // ---------------------------------------------------------------
  // Clip to the panel and add the RAM offset
  // ---------------------------------------------------------------
  logic signed [16:0] x_s, y_s, w_s, h_s;
  logic signed [16:0] end_x, end_y, endc_x, endc_y, st_x, st_y;
  logic signed [16:0] span_x, span_y;
  logic               clip_empty;
  logic [15:0]        off_x, off_y;
  logic [15:0]        x0_d, y0_d;
  logic [ColW-1:0]    w_d;
  logic [RowW-1:0]    h_d;

  always_comb begin
    x_s = 17'(req_q.rect_x);
    y_s = 17'(req_q.rect_y);
    w_s = 17'(req_q.rect_width);
    h_s = 17'(req_q.rect_height);
    end_x = x_s + w_s;
    end_y = y_s + h_s;
    clip_empty = (w_s <= 17'sd0) || (h_s <= 17'sd0) || (x_s >= ColsS) ||
                 (y_s >= RowsS) || (end_x <= 17'sd0) || (end_y <= 17'sd0);
    st_x   = (x_s < 17'sd0) ? 17'sd0 : x_s;
    st_y   = (y_s < 17'sd0) ? 17'sd0 : y_s;
    endc_x = (end_x > ColsS) ? ColsS : end_x;
    endc_y = (end_y > RowsS) ? RowsS : end_y;
    span_x = endc_x - st_x;
    span_y = endc_y - st_y;
    w_d    = span_x[ColW-1:0];
    h_d    = span_y[RowW-1:0];
    off_x  = (orient_q == ORIENT_COL_SHIFT) ? OffX : 16'd0;
    off_y  = (orient_q == ORIENT_ROW_SHIFT) ? OffY : 16'd0;
    x0_d   = off_x + st_x[15:0];
    y0_d   = off_y + st_y[15:0];
  end

  // ---------------------------------------------------------------
  // Job register and item sequencer
  // ---------------------------------------------------------------
  logic [15:0]     x0_q, y0_q, color_q;
  logic [ColW-1:0] w_q;
  logic [RowW-1:0] h_q;
  logic            job_valid_q;
  logic [3:0]      idx_q;
  logic            out_load;
  logic            job_free;
  logic            job_load;

  assign out_load = job_valid_q && (!out_valid_o || out_ready_i);
  assign job_free = !job_valid_q || (out_load && (idx_q == SeqLast));
  assign req_take = req_valid_q && (clip_empty || job_free);
  assign job_load = req_valid_q && !clip_empty && job_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= 4'd0;
    end else if (job_load) begin
      job_valid_q <= 1'b1;
      idx_q       <= 4'd0;
    end else if (out_load) begin
      // advance through the stream, drop the job after the color run
      job_valid_q <= (idx_q != SeqLast);
      idx_q       <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      x0_q    <= x0_d;
      y0_q    <= y0_d;
      w_q     <= w_d;
      h_q     <= h_d;
      color_q <= req_q.fill_color;
    end
  end

  // Window end addresses and saturated pixel count
  logic [15:0]     x1, y1;
  logic [PixW-1:0] pix_full;
  logic [31:0]     pix_wide;
  logic [15:0]     pix_sat;
  fill_item_t      item_d;

  always_comb begin
    x1       = x0_q + 16'(w_q) - 16'd1;
    y1       = y0_q + 16'(h_q) - 16'd1;
    pix_full = PixW'(w_q) * PixW'(h_q);
    pix_wide = 32'(pix_full);
    pix_sat  = (pix_wide > 32'h0000_FFFF) ? 16'hFFFF : pix_wide[15:0];

    item_d = '0;
    item_d.item_kind = KIND_PARAM;
    unique case (idx_q)
      4'd0: begin
        item_d.item_kind = KIND_CMD;
        item_d.wire_byte = OP_COLSET;
      end
      4'd1:  item_d.wire_byte = x0_q[15:8];
      4'd2:  item_d.wire_byte = x0_q[7:0];
      4'd3:  item_d.wire_byte = x1[15:8];
      4'd4:  item_d.wire_byte = x1[7:0];
      4'd5: begin
        item_d.item_kind = KIND_CMD;
        item_d.wire_byte = OP_ROWSET;
      end
      4'd6:  item_d.wire_byte = y0_q[15:8];
      4'd7:  item_d.wire_byte = y0_q[7:0];
      4'd8:  item_d.wire_byte = y1[15:8];
      4'd9:  item_d.wire_byte = y1[7:0];
      4'd10: begin
        item_d.item_kind = KIND_CMD;
        item_d.wire_byte = OP_MEMWR;
      end
      4'd11: begin
        item_d.item_kind  = KIND_RUN;
        item_d.run_color  = color_q;
        item_d.run_pixels = pix_sat;
        item_d.final_item = 1'b1;
      end
      default: item_d = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic       out_valid_q;
  fill_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
